### hdl/octp_pkg.sv
// shared types, constants and helpers for the octree cell locator
`timescale 1ns / 1ps

package octp_pkg;

  localparam int unsigned MAX_LEVELS = 9;
  localparam int unsigned FRAC_BITS  = 16;

  localparam int unsigned LVL_W    = 4;
  localparam int unsigned GRID_W   = MAX_LEVELS - 1;
  localparam int unsigned CODE_W   = 3 * GRID_W;
  localparam int unsigned WIDE_W   = (CODE_W > 25) ? CODE_W : 25;
  localparam int unsigned GFULL_W  = (GRID_W > 8) ? GRID_W : 8;
  localparam int unsigned WHOLE_W  = 64 - 2 * FRAC_BITS;
  localparam int unsigned DIFF_W   = 33;
  localparam int unsigned IN_W     = 104;
  localparam int unsigned OUT_W    = 80;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0]      RECIP_ONE = 32'(1) << FRAC_BITS;
  localparam logic [LVL_W-1:0] LC_RESET  = LVL_W'(9);
  localparam logic [LVL_W-1:0] LC_MAX    = LVL_W'(MAX_LEVELS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_X       = 3'd0,
    CFG_MIN_Y       = 3'd1,
    CFG_MIN_Z       = 3'd2,
    CFG_RECIP_X     = 3'd3,
    CFG_RECIP_Y     = 3'd4,
    CFG_RECIP_Z     = 3'd5,
    CFG_LEVEL_COUNT = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CLAMPED   = 2'd1,
    ST_BAD_LEVEL = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic [31:0]        recip_x;
    logic [31:0]        recip_y;
    logic [31:0]        recip_z;
    logic [LVL_W-1:0]   level_count;
  } cfg_t;

  // one classified point waiting for the back end
  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_x;
    logic signed [DIFF_W-1:0] diff_y;
    logic signed [DIFF_W-1:0] diff_z;
    logic [LVL_W-1:0]         level;
    logic [LVL_W-1:0]         shift;
    logic                     bad;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } fifo_stat_t;

  // (8^level - 1) / 7 is one set bit in every triple below the level
  function automatic logic [WIDE_W-1:0] level_base(input logic [LVL_W-1:0] level);
    logic [WIDE_W-1:0] b;
    b = '0;
    for (int unsigned i = 0; i < GRID_W; i++) begin
      if (LVL_W'(i) < level) begin
        b[3*i] = 1'b1;
      end
    end
    return b;
  endfunction

endpackage

### hdl/octp_front.sv
// front end: takes points, offsets them by the box minimum and checks the level
`timescale 1ns / 1ps

module octp_front (
  input  logic [octp_pkg::IN_W-1:0] s_axis_tdata,  // point_x, point_y, point_z, tree_level
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  octp_pkg::cfg_t            cfg_i,
  input  octp_pkg::fifo_stat_t      fifo_stat_i,
  output logic                      push_o,
  output octp_pkg::entry_t          entry_o
);

  logic signed [31:0]           px, py, pz;
  logic [octp_pkg::LVL_W-1:0]   level;
  logic [octp_pkg::LVL_W-1:0]   lc_eff;

  assign px    = s_axis_tdata[31:0];
  assign py    = s_axis_tdata[63:32];
  assign pz    = s_axis_tdata[95:64];
  assign level = s_axis_tdata[96 +: octp_pkg::LVL_W];

  assign s_axis_tready = !fifo_stat_i.full;
  assign push_o        = s_axis_tvalid && !fifo_stat_i.full;

  always_comb begin
    if (cfg_i.level_count == '0 || cfg_i.level_count > octp_pkg::LC_MAX) begin
      lc_eff = octp_pkg::LC_MAX;
    end else begin
      lc_eff = cfg_i.level_count;
    end
    entry_o.diff_x = {px[31], px} - {cfg_i.min_x[31], cfg_i.min_x};
    entry_o.diff_y = {py[31], py} - {cfg_i.min_y[31], cfg_i.min_y};
    entry_o.diff_z = {pz[31], pz} - {cfg_i.min_z[31], cfg_i.min_z};
    entry_o.level  = level;
    entry_o.bad    = (level >= lc_eff);
    entry_o.shift  = entry_o.bad ? '0 : (lc_eff - octp_pkg::LVL_W'(1) - level);
  end

endmodule

### hdl/octp_fifo.sv
// short queue between the front and back ends
`timescale 1ns / 1ps

module octp_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  octp_pkg::entry_t     entry_i,
  input  logic                 pop_i,
  output octp_pkg::fifo_stat_t stat_o,
  output octp_pkg::entry_t     entry_o
);

  octp_pkg::entry_t                  mem_q [octp_pkg::FIFO_DEPTH];
  logic [octp_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [octp_pkg::FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [octp_pkg::FIFO_CNT_W-1:0]   count_q, count_d;

  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == octp_pkg::FIFO_CNT_W'(octp_pkg::FIFO_DEPTH));
  assign entry_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + octp_pkg::FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + octp_pkg::FIFO_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + octp_pkg::FIFO_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - octp_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= octp_pkg::FIFO_CNT_W'(octp_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

### hdl/octp_back.sv
// back end: scale, shift to level, saturate, interleave and index
`timescale 1ns / 1ps

module octp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  octp_pkg::cfg_t             cfg_i,
  input  octp_pkg::fifo_stat_t       fifo_stat_i,
  input  octp_pkg::entry_t           entry_i,
  output logic                       pop_o,
  output logic [octp_pkg::OUT_W-1:0] m_axis_tdata,  // morton_code, node_index, grid_x,
                                                    // grid_y, grid_z, status
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready
);

  typedef struct packed {
    logic [31:0]                 mag_x;
    logic [31:0]                 mag_y;
    logic [31:0]                 mag_z;
    logic [2:0]                  neg;
    logic [octp_pkg::LVL_W-1:0]  level;
    logic [octp_pkg::LVL_W-1:0]  shift;
    logic                        bad;
  } mag_stage_t;

  typedef struct packed {
    logic [octp_pkg::WHOLE_W-1:0] whole_x;
    logic [octp_pkg::WHOLE_W-1:0] whole_y;
    logic [octp_pkg::WHOLE_W-1:0] whole_z;
    logic [2:0]                   neg;
    logic [octp_pkg::LVL_W-1:0]   level;
    logic [octp_pkg::LVL_W-1:0]   shift;
    logic                         bad;
  } prod_stage_t;

  logic        en;
  logic        m_valid_q, p_valid_q, o_valid_q;
  mag_stage_t  m_q, m_d;
  prod_stage_t p_q, p_d;
  logic [octp_pkg::OUT_W-1:0] out_q, out_d;

  assign en            = !o_valid_q || m_axis_tready;
  assign pop_o         = en && fifo_stat_i.valid;
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = out_q;

  function automatic logic [31:0] abs33(input logic signed [octp_pkg::DIFF_W-1:0] d);
    logic [octp_pkg::DIFF_W-1:0] m;
    m = d[octp_pkg::DIFF_W-1] ? -d : d;
    return m[31:0];
  endfunction

  function automatic logic [octp_pkg::WHOLE_W-1:0] scale(input logic [31:0] mag,
                                                         input logic [31:0] recip);
    logic [63:0] prod;
    prod = 64'(mag) * 64'(recip);
    return octp_pkg::WHOLE_W'(prod >> (2 * octp_pkg::FRAC_BITS));
  endfunction

  // saturated cell at the level; bit GRID_W carries the clamp flag
  function automatic logic [octp_pkg::GRID_W:0] to_cell(
      input logic [octp_pkg::WHOLE_W-1:0] whole, input logic neg,
      input logic [octp_pkg::LVL_W-1:0] shift, input logic [octp_pkg::LVL_W-1:0] level);
    logic [octp_pkg::WHOLE_W-1:0] sh;
    logic [octp_pkg::GRID_W:0]    lim;
    logic                         over;
    sh   = whole >> shift;
    over = |(sh >> level);
    lim  = ((octp_pkg::GRID_W+1)'(1) << level) - (octp_pkg::GRID_W+1)'(1);
    if (neg) begin
      return {|whole, {octp_pkg::GRID_W{1'b0}}};
    end else if (over) begin
      return {1'b1, lim[octp_pkg::GRID_W-1:0]};
    end else begin
      return {1'b0, sh[octp_pkg::GRID_W-1:0]};
    end
  endfunction

  always_comb begin
    m_d.mag_x = abs33(entry_i.diff_x);
    m_d.mag_y = abs33(entry_i.diff_y);
    m_d.mag_z = abs33(entry_i.diff_z);
    m_d.neg   = {entry_i.diff_z[octp_pkg::DIFF_W-1], entry_i.diff_y[octp_pkg::DIFF_W-1],
                 entry_i.diff_x[octp_pkg::DIFF_W-1]};
    m_d.level = entry_i.level;
    m_d.shift = entry_i.shift;
    m_d.bad   = entry_i.bad;

    p_d.whole_x = scale(m_q.mag_x, cfg_i.recip_x);
    p_d.whole_y = scale(m_q.mag_y, cfg_i.recip_y);
    p_d.whole_z = scale(m_q.mag_z, cfg_i.recip_z);
    p_d.neg     = m_q.neg;
    p_d.level   = m_q.level;
    p_d.shift   = m_q.shift;
    p_d.bad     = m_q.bad;
  end

  logic [octp_pkg::GRID_W:0]    cx, cy, cz;
  logic [octp_pkg::WIDE_W-1:0]  code, node;
  logic [octp_pkg::GFULL_W-1:0] gx, gy, gz;
  octp_pkg::status_e            status;

  always_comb begin
    cx = to_cell(p_q.whole_x, p_q.neg[0], p_q.shift, p_q.level);
    cy = to_cell(p_q.whole_y, p_q.neg[1], p_q.shift, p_q.level);
    cz = to_cell(p_q.whole_z, p_q.neg[2], p_q.shift, p_q.level);
    code = '0;
    for (int unsigned i = 0; i < octp_pkg::GRID_W; i++) begin
      code[3*i]   = cx[i];
      code[3*i+1] = cy[i];
      code[3*i+2] = cz[i];
    end
    node = octp_pkg::level_base(p_q.level) + code;
    gx   = octp_pkg::GFULL_W'(cx[octp_pkg::GRID_W-1:0]);
    gy   = octp_pkg::GFULL_W'(cy[octp_pkg::GRID_W-1:0]);
    gz   = octp_pkg::GFULL_W'(cz[octp_pkg::GRID_W-1:0]);
    if (p_q.bad) begin
      status = octp_pkg::ST_BAD_LEVEL;
      out_d  = {5'b0, status, 73'b0};
    end else begin
      status = (cx[octp_pkg::GRID_W] || cy[octp_pkg::GRID_W] || cz[octp_pkg::GRID_W])
               ? octp_pkg::ST_CLAMPED : octp_pkg::ST_OK;
      out_d  = {5'b0, status, gz[7:0], gy[7:0], gx[7:0], node[24:0], code[23:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= pop_o;
      p_valid_q <= m_valid_q;
      o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q   <= m_d;
      p_q   <= p_d;
      out_q <= out_d;
    end
  end

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !en) |=> p_valid_q)
    else $error("word lost in back end while stalled");

  a_bad_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && out_q[74:73] == octp_pkg::ST_BAD_LEVEL) |-> out_q[72:0] == '0)
    else $error("bad level word carries nonzero fields");

endmodule

### hdl/octree_point_to_morton_cell.sv
// top level of the octree cell locator: configuration registers and wiring
`timescale 1ns / 1ps

// Maps a signed Q16.16 point and an octree level to the Morton code, linear node
// index, grid coordinates and status of the cell that holds it.
// Input words arrive on s_axis (tvalid/tready/tdata); result words leave on
// m_axis. Exactly one result word per input word, in order.
// The configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes one field
// per write, chosen by cfg_idx_i: the box minimum, a per-axis scale factor or
// the level count; write it only while no word is in flight.
// Between input acceptance and the result on m_axis a word passes through
// the queue, then the magnitude and product registers, and then the output
// register.
// Throughput is one word per cycle while m_axis is not stalled; the back end has
// three 32x32 multipliers, one per axis, each used once per word.
// A stalled receiver freezes the back end; the queue keeps taking words until
// it holds four, then s_axis_tready drops.
// Reset empties the queue and pipeline and loads the defaults: box minimum 0,
// scale 1.0 per axis, level count 9.

module octree_point_to_morton_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [octp_pkg::IN_W-1:0]     s_axis_tdata,  // point_x, point_y, point_z,
                                                       // tree_level
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  output logic [octp_pkg::OUT_W-1:0]    m_axis_tdata,  // morton_code, node_index, grid_x,
                                                       // grid_y, grid_z, status
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [octp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i
);

  octp_pkg::cfg_t       cfg_q, cfg_d;
  octp_pkg::fifo_stat_t fifo_stat;
  octp_pkg::entry_t     push_entry, pop_entry;
  logic                 push, pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (octp_pkg::cfg_idx_e'(cfg_idx_i))
        octp_pkg::CFG_MIN_X:       cfg_d.min_x       = cfg_wdata_i;
        octp_pkg::CFG_MIN_Y:       cfg_d.min_y       = cfg_wdata_i;
        octp_pkg::CFG_MIN_Z:       cfg_d.min_z       = cfg_wdata_i;
        octp_pkg::CFG_RECIP_X:     cfg_d.recip_x     = cfg_wdata_i;
        octp_pkg::CFG_RECIP_Y:     cfg_d.recip_y     = cfg_wdata_i;
        octp_pkg::CFG_RECIP_Z:     cfg_d.recip_z     = cfg_wdata_i;
        octp_pkg::CFG_LEVEL_COUNT: cfg_d.level_count = cfg_wdata_i[octp_pkg::LVL_W-1:0];
        default:                   cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_x       <= '0;
      cfg_q.min_y       <= '0;
      cfg_q.min_z       <= '0;
      cfg_q.recip_x     <= octp_pkg::RECIP_ONE;
      cfg_q.recip_y     <= octp_pkg::RECIP_ONE;
      cfg_q.recip_z     <= octp_pkg::RECIP_ONE;
      cfg_q.level_count <= octp_pkg::LC_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  octp_front u_front (
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .cfg_i         (cfg_q),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  octp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .stat_o  (fifo_stat),
    .entry_o (pop_entry)
  );

  octp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .fifo_stat_i   (fifo_stat),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

endmodule
